// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion helpers used by gate_field_combiner_top
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property under clk, disabled in reset
`define CHECK_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication under clk, disabled in reset
`define CHECK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/gfc_pkg.sv
// ----------------------------------------------------------------------------
// gfc_pkg
// constants and codes shared by the gate field combiner files
// ----------------------------------------------------------------------------
package gfc_pkg;

    localparam int Q_BITS        = 48;
    localparam int Q_FRAC        = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;
    localparam int QMUL_STAGES   = 6;

    localparam logic signed [Q_BITS-1:0] Q_ONE = 48'sd16777216;
    localparam logic signed [Q_BITS-1:0] Q_MAX = {1'b0, {(Q_BITS-1){1'b1}}};
    localparam logic signed [Q_BITS-1:0] Q_MIN = {1'b1, {(Q_BITS-1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_OP_MODE     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BAD_VALUE   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_RGAIN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_OFF   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_RGAIN = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_OFF  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_GAIN    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_OFF     = 3'd7;

    // operating modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_MERGE = 2'd1;
    localparam logic [1:0] MODE_MULT  = 2'd2;
    localparam logic [1:0] MODE_SUB   = 2'd3;

    // combine selects for the scaled path
    localparam logic [2:0] SEL_SUM  = 3'd0;
    localparam logic [2:0] SEL_A    = 3'd1;
    localparam logic [2:0] SEL_B    = 3'd2;
    localparam logic [2:0] SEL_PROD = 3'd3;
    localparam logic [2:0] SEL_DIFF = 3'd4;

endpackage

// File: sv/gfc_qmul.sv
// ----------------------------------------------------------------------------
// gfc_qmul
// pipelined signed q24.24 multiply, truncated toward zero, saturated to 48 bits
// ----------------------------------------------------------------------------
module gfc_qmul #(
    parameter int A_BITS = 49
) (
    input  logic                               clk,
    input  logic signed [A_BITS-1:0]           a,
    input  logic signed [gfc_pkg::Q_BITS-1:0]  b,
    output logic signed [gfc_pkg::Q_BITS-1:0]  p
);
    import gfc_pkg::*;

    localparam int A_LO   = (A_BITS + 1) / 2;
    localparam int A_HI   = A_BITS - A_LO;
    localparam int B_LO   = Q_BITS / 2;
    localparam int B_HI   = Q_BITS - B_LO;
    localparam int P_BITS = A_BITS + Q_BITS;
    localparam int R_BITS = P_BITS - Q_FRAC;

    logic [A_BITS-1:0]       ma_reg, ma_next;
    logic [Q_BITS-1:0]       mb_reg, mb_next;
    logic [A_LO+B_LO-1:0]    ll_reg, ll_next;
    logic [A_LO+B_HI-1:0]    lh_reg, lh_next;
    logic [A_HI+B_LO-1:0]    hl_reg, hl_next;
    logic [A_HI+B_HI-1:0]    hh_reg, hh_next;
    logic [P_BITS-1:0]       slo_reg, slo_next;
    logic [A_HI+Q_BITS-1:0]  shi_reg, shi_next;
    logic [P_BITS-1:0]       prod_reg, prod_next;
    logic [R_BITS-1:0]       quot;
    logic [Q_BITS-1:0]       lim;
    logic [Q_BITS-1:0]       r_reg, r_next;
    logic signed [Q_BITS-1:0] p_reg, p_next;
    logic [QMUL_STAGES-2:0]  neg_reg;

    always_comb
    begin
        ma_next = a[A_BITS-1] ? A_BITS'(-a) : A_BITS'(a);
        mb_next = b[Q_BITS-1] ? Q_BITS'(-b) : Q_BITS'(b);

        ll_next = (A_LO+B_LO)'(ma_reg[A_LO-1:0]) * (A_LO+B_LO)'(mb_reg[B_LO-1:0]);
        lh_next = (A_LO+B_HI)'(ma_reg[A_LO-1:0]) * (A_LO+B_HI)'(mb_reg[Q_BITS-1:B_LO]);
        hl_next = (A_HI+B_LO)'(ma_reg[A_BITS-1:A_LO]) * (A_HI+B_LO)'(mb_reg[B_LO-1:0]);
        hh_next = (A_HI+B_HI)'(ma_reg[A_BITS-1:A_LO]) * (A_HI+B_HI)'(mb_reg[Q_BITS-1:B_LO]);

        slo_next = P_BITS'(ll_reg) + (P_BITS'(lh_reg) << B_LO);
        shi_next = (A_HI+Q_BITS)'(hl_reg) + ((A_HI+Q_BITS)'(hh_reg) << B_LO);

        prod_next = slo_reg + (P_BITS'(shi_reg) << A_LO);

        // magnitude limit depends on the result sign
        quot   = prod_reg[P_BITS-1:Q_FRAC];
        lim    = neg_reg[3] ? Q_BITS'(Q_MIN) : Q_BITS'(Q_MAX);
        r_next = (quot > R_BITS'(lim)) ? lim : quot[Q_BITS-1:0];

        p_next = neg_reg[4] ? $signed(Q_BITS'(-r_reg)) : $signed(r_reg);
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= {neg_reg[QMUL_STAGES-3:0], a[A_BITS-1] ^ b[Q_BITS-1]};
        ll_reg   <= ll_next;
        lh_reg   <= lh_next;
        hl_reg   <= hl_next;
        hh_reg   <= hh_next;
        slo_reg  <= slo_next;
        shi_reg  <= shi_next;
        prod_reg <= prod_next;
        r_reg    <= r_next;
        p_reg    <= p_next;
    end

    assign p = p_reg;

endmodule

// File: sv/gate_field_combiner_top.sv
// ----------------------------------------------------------------------------
// gate_field_combiner_top
// per-gate combiner of two scaled field samples in add, merge, multiply or
// subtract mode, with bad-value handling and an edit boundary
//
// channel  | handshake                 | payload
// ---------+---------------------------+-------------------------------------
// input    | start, busy               | first_sample, second_sample,
//          |                           | old_out_sample, in_boundary
// result   | done                      | out_sample, was_edited
// config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// one gate enters every cycle; busy stays low and cfg_ready stays high
// a result shows on done after its start transfer has passed through three
// six-stage q24.24 multipliers in series plus the operand and output stages
// reset clears the valid pipe and loads the default register values
// the result side cannot stall, so the pipe always advances
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gate_field_combiner_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [SAMPLE_BITS-1:0]         first_sample,
    input  logic signed [SAMPLE_BITS-1:0]         second_sample,
    input  logic signed [SAMPLE_BITS-1:0]         old_out_sample,
    input  logic                                  in_boundary,
    output logic                                  done,
    output logic signed [SAMPLE_BITS-1:0]         out_sample,
    output logic                                  was_edited,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gfc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [gfc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import gfc_pkg::*;

    localparam int X_BITS     = ((SAMPLE_BITS + Q_FRAC) > Q_BITS ?
                                 (SAMPLE_BITS + Q_FRAC) : Q_BITS) + 1;
    localparam int T_BITS     = Q_BITS + 1;
    localparam int D_BITS     = T_BITS - Q_FRAC;
    localparam int C_BITS     = (D_BITS > SAMPLE_BITS ? D_BITS : SAMPLE_BITS) + 1;
    localparam int SIDE_DEPTH = 3 * QMUL_STAGES + 4;
    localparam int IDX_COMB   = QMUL_STAGES;
    localparam int IDX_LAST   = SIDE_DEPTH - 1;
    localparam int LAT        = 3 * QMUL_STAGES + 6;

    localparam logic signed [C_BITS-1:0] S_MAX_C =
        {{(C_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [C_BITS-1:0] S_MIN_C = ~S_MAX_C;
    localparam logic [T_BITS-1:0] FRAC_MASK = {{(T_BITS-Q_FRAC){1'b0}}, {Q_FRAC{1'b1}}};

    typedef struct packed {
        logic                          bnd;
        logic signed [SAMPLE_BITS-1:0] old;
        logic signed [SAMPLE_BITS-1:0] raw;
        logic                          use_resc;
        logic                          take;
        logic [2:0]                    sel;
    } side_t;

    // configuration registers
    logic [1:0]               op_mode_reg;
    logic signed [15:0]       bad_value_reg;
    logic signed [Q_BITS-1:0] frg_reg, fo_reg, srg_reg, so_reg, og_reg, oo_reg;
    logic                     rs_reg, rs_next;
    logic [Q_BITS-1:0]        mag_s, mag_g;
    logic                     pow_pair;

    // input stage
    logic                          in_vld_reg;
    logic signed [SAMPLE_BITS-1:0] in_a_reg, in_s_reg, in_old_reg;
    logic                          in_bnd_reg;

    // operand stage and side pipe
    logic signed [SAMPLE_BITS-1:0] bad_s;
    logic                          a_ok, s_ok;
    side_t                         side_next;
    side_t                         side_reg [SIDE_DEPTH];
    logic [SIDE_DEPTH-1:0]         vld_reg;
    logic signed [X_BITS-1:0]      xa_reg, xa_next, xs_reg, xs_next;

    // scaled path
    logic signed [Q_BITS-1:0]      ua, us, uw, uo;
    logic signed [Q_BITS:0]        sum_w, diff_w;
    logic signed [Q_BITS-1:0]      sum_sat, diff_sat;
    logic signed [Q_BITS-1:0]      cm_a_reg, cm_a_next, cm_b_reg, cm_b_next;
    logic signed [T_BITS-1:0]      t_reg, t_next;
    logic [T_BITS-1:0]             t_adj;
    logic signed [D_BITS-1:0]      d_reg, d_next;
    logic signed [C_BITS-1:0]      d_ext;
    logic signed [SAMPLE_BITS-1:0] d_sat;

    // result registers
    logic                          done_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, out_sample_next;
    logic                          was_edited_reg, was_edited_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg   <= MODE_ADD;
            bad_value_reg <= 16'sh8000;
            frg_reg       <= Q_ONE;
            fo_reg        <= '0;
            srg_reg       <= Q_ONE;
            so_reg        <= '0;
            og_reg        <= Q_ONE;
            oo_reg        <= '0;
            rs_reg        <= 1'b0;
        end
        else
        begin
            rs_reg <= rs_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OP_MODE:      op_mode_reg   <= cfg_data[1:0];
                    REG_BAD_VALUE:    bad_value_reg <= cfg_data[15:0];
                    REG_FIRST_RGAIN:  frg_reg       <= cfg_data;
                    REG_FIRST_OFF:    fo_reg        <= cfg_data;
                    REG_SECOND_RGAIN: srg_reg       <= cfg_data;
                    REG_SECOND_OFF:   so_reg        <= cfg_data;
                    REG_OUT_GAIN:     og_reg        <= cfg_data;
                    REG_OUT_OFF:      oo_reg        <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // rescale needed unless scalings match and source gain times out gain is one
    always_comb
    begin
        mag_s    = srg_reg[Q_BITS-1] ? Q_BITS'(-srg_reg) : Q_BITS'(srg_reg);
        mag_g    = og_reg[Q_BITS-1] ? Q_BITS'(-og_reg) : Q_BITS'(og_reg);
        pow_pair = 1'b0;
        for (int i = 1; i < Q_BITS; i++)
        begin
            pow_pair = pow_pair | (mag_s[i] & mag_g[Q_BITS-i]);
        end
        rs_next = (frg_reg != srg_reg) || (fo_reg != so_reg) || (so_reg != oo_reg)
                  || (srg_reg[Q_BITS-1] != og_reg[Q_BITS-1])
                  || ((mag_s & (mag_s - Q_BITS'(1))) != '0)
                  || ((mag_g & (mag_g - Q_BITS'(1))) != '0)
                  || !pow_pair;
    end

    // input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_a_reg   <= first_sample;
        in_s_reg   <= second_sample;
        in_old_reg <= old_out_sample;
        in_bnd_reg <= in_boundary;
    end

    // operand stage: bad flags, raw-path result, unscale operands
    always_comb
    begin
        bad_s = SAMPLE_BITS'(bad_value_reg);
        a_ok  = in_a_reg != bad_s;
        s_ok  = in_s_reg != bad_s;

        xa_next = $signed({{(X_BITS-SAMPLE_BITS-Q_FRAC){in_a_reg[SAMPLE_BITS-1]}},
                           in_a_reg, {Q_FRAC{1'b0}}}) - X_BITS'(fo_reg);
        xs_next = $signed({{(X_BITS-SAMPLE_BITS-Q_FRAC){in_s_reg[SAMPLE_BITS-1]}},
                           in_s_reg, {Q_FRAC{1'b0}}}) - X_BITS'(so_reg);

        side_next.bnd      = in_bnd_reg;
        side_next.old      = in_old_reg;
        side_next.use_resc = rs_reg || (op_mode_reg == MODE_MULT);
        side_next.raw      = bad_s;
        side_next.take     = 1'b0;
        side_next.sel      = SEL_A;

        case (op_mode_reg)
            MODE_ADD:
            begin
                side_next.take = a_ok || s_ok;
                if (a_ok && s_ok)
                begin
                    side_next.raw = in_a_reg + in_s_reg;
                    side_next.sel = SEL_SUM;
                end
                else if (a_ok)
                begin
                    side_next.raw = in_a_reg;
                    side_next.sel = SEL_A;
                end
                else if (s_ok)
                begin
                    side_next.raw = in_s_reg;
                    side_next.sel = SEL_B;
                end
            end
            MODE_MERGE:
            begin
                side_next.take = a_ok || s_ok;
                side_next.raw  = a_ok ? in_a_reg : in_s_reg;
                side_next.sel  = a_ok ? SEL_A : SEL_B;
            end
            MODE_MULT:
            begin
                side_next.take = a_ok && s_ok;
                side_next.sel  = SEL_PROD;
            end
            default:
            begin
                side_next.take = a_ok && s_ok;
                side_next.sel  = SEL_DIFF;
                if (a_ok && s_ok)
                begin
                    side_next.raw = in_s_reg - in_a_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[SIDE_DEPTH-2:0], in_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        xa_reg      <= xa_next;
        xs_reg      <= xs_next;
        side_reg[0] <= side_next;
        for (int i = 1; i < SIDE_DEPTH; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    // unscale both samples
    gfc_qmul #(.A_BITS(X_BITS)) u_unscale_a (
        .clk (clk),
        .a   (xa_reg),
        .b   (frg_reg),
        .p   (ua)
    );

    gfc_qmul #(.A_BITS(X_BITS)) u_unscale_s (
        .clk (clk),
        .a   (xs_reg),
        .b   (srg_reg),
        .p   (us)
    );

    // combine stage; non-product selects pass through the middle multiplier times one
    always_comb
    begin
        sum_w    = {ua[Q_BITS-1], ua} + {us[Q_BITS-1], us};
        diff_w   = {us[Q_BITS-1], us} - {ua[Q_BITS-1], ua};
        sum_sat  = (sum_w[Q_BITS] != sum_w[Q_BITS-1]) ?
                   (sum_w[Q_BITS] ? Q_MIN : Q_MAX) : sum_w[Q_BITS-1:0];
        diff_sat = (diff_w[Q_BITS] != diff_w[Q_BITS-1]) ?
                   (diff_w[Q_BITS] ? Q_MIN : Q_MAX) : diff_w[Q_BITS-1:0];
        cm_b_next = Q_ONE;
        case (side_reg[IDX_COMB].sel)
            SEL_SUM:  cm_a_next = sum_sat;
            SEL_A:    cm_a_next = ua;
            SEL_B:    cm_a_next = us;
            SEL_PROD:
            begin
                cm_a_next = ua;
                cm_b_next = us;
            end
            SEL_DIFF: cm_a_next = diff_sat;
            default:  cm_a_next = ua;
        endcase
    end

    always_ff @(posedge clk)
    begin
        cm_a_reg <= cm_a_next;
        cm_b_reg <= cm_b_next;
    end

    gfc_qmul #(.A_BITS(Q_BITS)) u_mid (
        .clk (clk),
        .a   (cm_a_reg),
        .b   (cm_b_reg),
        .p   (uw)
    );

    gfc_qmul #(.A_BITS(Q_BITS)) u_rescale (
        .clk (clk),
        .a   (uw),
        .b   (og_reg),
        .p   (uo)
    );

    // bias, truncate toward zero, saturate, final select
    always_comb
    begin
        t_next = {uo[Q_BITS-1], uo} + {oo_reg[Q_BITS-1], oo_reg};
        t_adj  = t_reg[T_BITS-1] ? (T_BITS'(t_reg) + FRAC_MASK) : T_BITS'(t_reg);
        d_next = t_adj[T_BITS-1:Q_FRAC];

        d_ext = C_BITS'(d_reg);
        if (d_ext > S_MAX_C)
        begin
            d_sat = SAMPLE_BITS'(S_MAX_C);
        end
        else if (d_ext < S_MIN_C)
        begin
            d_sat = SAMPLE_BITS'(S_MIN_C);
        end
        else
        begin
            d_sat = SAMPLE_BITS'(d_ext);
        end

        if (!side_reg[IDX_LAST].bnd)
        begin
            out_sample_next = side_reg[IDX_LAST].old;
            was_edited_next = 1'b0;
        end
        else
        begin
            was_edited_next = 1'b1;
            if (side_reg[IDX_LAST].use_resc)
            begin
                out_sample_next = side_reg[IDX_LAST].take ? d_sat : bad_s;
            end
            else
            begin
                out_sample_next = side_reg[IDX_LAST].raw;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg          <= t_next;
        d_reg          <= d_next;
        out_sample_reg <= out_sample_next;
        was_edited_reg <= was_edited_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[IDX_LAST];
        end
    end

    assign done       = done_reg;
    assign out_sample = out_sample_reg;
    assign was_edited = was_edited_reg;

    `CHECK_IMPLY(a_done_has_start, done, $past(start, LAT), "result without start transfer")
    `CHECK_IMPLY(a_edit_flag, done, was_edited == $past(in_boundary, LAT), "edit flag mismatch")
    `CHECK_CLK(a_keep_old, !(done && !was_edited) || (out_sample == $past(old_out_sample, LAT)), "old sample not kept")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for gate_field_combiner_top: gates go in from a queue
// through a clocked driver, a clocked monitor checks every result against a
// q24.24 predictor that tracks the register settings. runs directed corner
// gates in all four modes, then random register settings and random gates
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gfc_pkg::*;

    localparam longint Q24_ONE   = longint'(Q_ONE);
    localparam longint Q48_TOP   = longint'(Q_MAX);
    localparam longint Q48_BOT   = longint'(Q_MIN);
    localparam int     QUIET_MAX = 2000;
    localparam int     TAIL      = 40;

    typedef struct packed {
        logic signed [15:0] first;
        logic signed [15:0] second;
        logic signed [15:0] old_out;
        logic               in_bnd;
    } gate_t;

    typedef struct packed {
        logic signed [15:0] value;
        logic               edited;
    } gate_result_t;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
    } reg_write_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] bad;
        logic signed [47:0] frg;
        logic signed [47:0] foff;
        logic signed [47:0] srg;
        logic signed [47:0] soff;
        logic signed [47:0] og;
        logic signed [47:0] ooff;
    } setting_t;

    logic                        clk;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic signed [15:0]          first_sample = '0;
    logic signed [15:0]          second_sample = '0;
    logic signed [15:0]          old_out_sample = '0;
    logic                        in_boundary = 1'b0;
    logic                        done;
    logic signed [15:0]          out_sample;
    logic                        was_edited;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data = '0;

    logic [1:0]                  sh_mode;
    logic signed [15:0]          sh_bad;
    logic signed [47:0]          sh_frg;
    logic signed [47:0]          sh_foff;
    logic signed [47:0]          sh_srg;
    logic signed [47:0]          sh_soff;
    logic signed [47:0]          sh_og;
    logic signed [47:0]          sh_ooff;

    gate_t                       gates_waiting[$];
    gate_result_t                results_due[$];
    reg_write_t                  reg_writes[$];
    gate_t                       cur_gate;
    gate_t                       next_gate;
    reg_write_t                  next_write;
    gate_result_t                want;
    int                          sender_idle_pct = 26;
    int                          fail_count = 0;
    int                          quiet_cycles = 0;

    gate_field_combiner_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_sample   (first_sample),
        .second_sample  (second_sample),
        .old_out_sample (old_out_sample),
        .in_boundary    (in_boundary),
        .done           (done),
        .out_sample     (out_sample),
        .was_edited     (was_edited),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // (a*b)/2^24 toward zero, clipped to signed 48 bits
    function automatic longint qmul_q24(longint a, longint b);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] q;
        logic [127:0] lim;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        q = ({64'd0, ma} * {64'd0, mb}) >> 24;
        lim = neg ? 128'h8000_0000_0000 : 128'h7fff_ffff_ffff;
        if (q > lim)
            q = lim;
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint clip48(longint v);
        if (v > Q48_TOP)
            return Q48_TOP;
        if (v < Q48_BOT)
            return Q48_BOT;
        return v;
    endfunction

    function automatic longint unscale_q24(logic signed [15:0] raw, longint off,
                                           longint rg);
        longint rl;
        rl = longint'(raw);
        return qmul_q24(rl * Q24_ONE - off, rg);
    endfunction

    function automatic logic [15:0] rescale_q24(longint v);
        longint t;
        longint q;
        t = qmul_q24(v, longint'(sh_og)) + longint'(sh_ooff);
        q = t / Q24_ONE;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic gate_result_t combine_gate(gate_t g);
        gate_result_t res;
        longint       sr;
        longint       og;
        longint       ua;
        longint       us;
        logic [63:0]  msr;
        logic [63:0]  mog;
        logic         a_ok;
        logic         s_ok;
        logic         rs;
        logic [15:0]  r;
        sr = longint'(sh_srg);
        og = longint'(sh_og);
        msr = (sr < 0) ? -sr : sr;
        mog = (og < 0) ? -og : og;
        rs = (sh_frg != sh_srg) || (sh_foff != sh_soff) || (sh_soff != sh_ooff)
             || ((sr < 0) != (og < 0))
             || (({64'd0, msr} * {64'd0, mog}) != (128'd1 << 48));
        a_ok = g.first != sh_bad;
        s_ok = g.second != sh_bad;
        ua = unscale_q24(g.first, longint'(sh_foff), longint'(sh_frg));
        us = unscale_q24(g.second, longint'(sh_soff), longint'(sh_srg));
        r = sh_bad;
        if (!g.in_bnd)
        begin
            res.value = g.old_out;
            res.edited = 1'b0;
            return res;
        end
        case (sh_mode)
            MODE_ADD:
                if (rs)
                begin
                    if (a_ok && s_ok)
                        r = rescale_q24(clip48(ua + us));
                    else if (a_ok)
                        r = rescale_q24(ua);
                    else if (s_ok)
                        r = rescale_q24(us);
                end
                else
                begin
                    if (a_ok && s_ok)
                        r = g.first + g.second;
                    else if (a_ok)
                        r = g.first;
                    else if (s_ok)
                        r = g.second;
                end
            MODE_MERGE:
                if (rs)
                begin
                    if (a_ok)
                        r = rescale_q24(ua);
                    else if (s_ok)
                        r = rescale_q24(us);
                end
                else
                    r = a_ok ? g.first : g.second;
            MODE_MULT:
                if (a_ok && s_ok)
                    r = rescale_q24(qmul_q24(ua, us));
            default:
                if (a_ok && s_ok)
                    r = rs ? rescale_q24(clip48(us - ua)) : g.second - g.first;
        endcase
        res.value = r;
        res.edited = 1'b1;
        return res;
    endfunction

    // gate driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            first_sample <= '0;
            second_sample <= '0;
            old_out_sample <= '0;
            in_boundary <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                results_due.push_back(combine_gate(cur_gate));
            if (!start || !busy)
            begin
                if (gates_waiting.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_gate = gates_waiting.pop_front();
                    cur_gate <= next_gate;
                    start <= 1'b1;
                    first_sample <= next_gate.first;
                    second_sample <= next_gate.second;
                    old_out_sample <= next_gate.old_out;
                    in_boundary <= next_gate.in_bnd;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // register write driver, keeps the predictor's copy of the registers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            sh_mode <= MODE_ADD;
            sh_bad <= -16'sd32768;
            sh_frg <= Q_ONE;
            sh_foff <= '0;
            sh_srg <= Q_ONE;
            sh_soff <= '0;
            sh_og <= Q_ONE;
            sh_ooff <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OP_MODE:      sh_mode <= cfg_data[1:0];
                    REG_BAD_VALUE:    sh_bad <= cfg_data[15:0];
                    REG_FIRST_RGAIN:  sh_frg <= cfg_data;
                    REG_FIRST_OFF:    sh_foff <= cfg_data;
                    REG_SECOND_RGAIN: sh_srg <= cfg_data;
                    REG_SECOND_OFF:   sh_soff <= cfg_data;
                    REG_OUT_GAIN:     sh_og <= cfg_data;
                    default:          sh_ooff <= cfg_data;
                endcase
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes.size() != 0)
                begin
                    next_write = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= next_write.idx;
                    cfg_data <= next_write.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: unexpected result out_sample=%0d was_edited=%0b",
                             $realtime, out_sample, was_edited);
                fail_count++;
            end
            else
            begin
                want = results_due.pop_front();
                if (out_sample !== want.value || was_edited !== want.edited)
                begin
                    if (fail_count < 10)
                        $display("%0t: mismatch exp %0d/%0b got %0d/%0b",
                                 $realtime, want.value, want.edited,
                                 out_sample, was_edited);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_MAX)
            begin
                $display("[gate_field_combiner_top] ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (gates_waiting.size() != 0 || start || results_due.size() != 0);
    endtask

    task automatic program_setting(setting_t c);
        wait_idle();
        reg_writes.push_back({REG_OP_MODE, 46'd0, c.mode});
        reg_writes.push_back({REG_BAD_VALUE, {32{c.bad[15]}}, c.bad});
        reg_writes.push_back({REG_FIRST_RGAIN, c.frg});
        reg_writes.push_back({REG_FIRST_OFF, c.foff});
        reg_writes.push_back({REG_SECOND_RGAIN, c.srg});
        reg_writes.push_back({REG_SECOND_OFF, c.soff});
        reg_writes.push_back({REG_OUT_GAIN, c.og});
        reg_writes.push_back({REG_OUT_OFF, c.ooff});
        do
            @(negedge clk);
        while (reg_writes.size() != 0 || cfg_valid);
    endtask

    task automatic send_gate(logic signed [15:0] a, logic signed [15:0] s,
                             logic signed [15:0] old, logic inb);
        gates_waiting.push_back({a, s, old, inb});
    endtask

    function automatic setting_t make_setting(logic [1:0] mode, logic signed [15:0] bad,
                                              logic signed [47:0] frg,
                                              logic signed [47:0] foff,
                                              logic signed [47:0] srg,
                                              logic signed [47:0] soff,
                                              logic signed [47:0] og,
                                              logic signed [47:0] ooff);
        return {mode, bad, frg, foff, srg, soff, og, ooff};
    endfunction

    function automatic logic signed [47:0] random48();
        logic signed [47:0] v;
        v[47:32] = 16'($urandom);
        v[31:0] = $urandom;
        return v;
    endfunction

    function automatic logic signed [47:0] pick_gain();
        logic signed [47:0] v;
        case ($urandom_range(5))
            0: return Q_ONE;
            1: return -Q_ONE;
            2, 3:
            begin
                v = 48'($urandom_range(32'd67108864, 32'd4194304));
                return $urandom_range(1) ? -v : v;
            end
            4: return $urandom_range(1) ? Q_MAX : Q_MIN;
            default: return random48();
        endcase
    endfunction

    function automatic logic signed [47:0] pick_offset();
        logic signed [47:0] v;
        case ($urandom_range(4))
            0: return '0;
            1, 2:
            begin
                v = 48'($urandom_range(2000));
                v = (v <<< 24) + 48'($urandom_range(24'hff_ffff));
                return $urandom_range(1) ? -v : v;
            end
            3: return $urandom_range(1) ? Q_MAX : Q_MIN;
            default: return random48();
        endcase
    endfunction

    function automatic setting_t random_setting(int p);
        setting_t           c;
        int                 k;
        logic signed [47:0] o;
        c.mode = 2'(p % 4);
        case ($urandom_range(3))
            0: c.bad = -16'sd32768;
            1: c.bad = 16'sd32767;
            2: c.bad = '0;
            default: c.bad = 16'($urandom);
        endcase
        if (p == 4)
        begin
            c.frg = Q_MAX; c.srg = Q_MAX; c.og = Q_MAX;
            c.foff = Q_MIN; c.soff = Q_MIN; c.ooff = Q_MIN;
        end
        else if (p == 9)
        begin
            c.frg = Q_MIN; c.srg = Q_MIN; c.og = Q_MIN;
            c.foff = Q_MAX; c.soff = Q_MAX; c.ooff = Q_MAX;
        end
        else if ($urandom_range(2) == 0)
        begin
            // matched scalings, takes the raw path outside multiply mode
            k = int'($urandom_range(16)) - 8;
            c.frg = 48'd1 << (24 + k);
            c.og = 48'd1 << (24 - k);
            if ($urandom_range(1))
            begin
                c.frg = -c.frg;
                c.og = -c.og;
            end
            c.srg = c.frg;
            o = pick_offset();
            c.foff = o; c.soff = o; c.ooff = o;
        end
        else
        begin
            c.frg = pick_gain(); c.srg = pick_gain(); c.og = pick_gain();
            c.foff = pick_offset(); c.soff = pick_offset(); c.ooff = pick_offset();
        end
        return c;
    endfunction

    function automatic logic signed [15:0] pick_sample(logic signed [15:0] bad);
        case ($urandom_range(9))
            0, 1: return bad;
            2: return 16'sd32767;
            3: return -16'sd32768;
            4: return '0;
            5: return 16'($urandom_range(600) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        setting_t c;
        int       n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        program_setting(make_setting(MODE_ADD, -16'sd32768, Q_ONE, '0, Q_ONE, '0,
                                     Q_ONE, '0));
        send_gate(16'sd32767, 16'sd1, 16'sd0, 1'b1);
        send_gate(-16'sd32768, 16'sd5, 16'sd0, 1'b1);
        send_gate(16'sd7, -16'sd32768, 16'sd0, 1'b1);
        send_gate(-16'sd32768, -16'sd32768, 16'sd0, 1'b1);
        send_gate(16'sd100, 16'sd200, -16'sd1234, 1'b0);
        send_gate(-16'sd32767, -16'sd32767, 16'sd32767, 1'b1);
        program_setting(make_setting(MODE_MERGE, -16'sd32768, Q_ONE, '0, Q_ONE, '0,
                                     Q_ONE, '0));
        send_gate(-16'sd32768, 16'sd9, 16'sd0, 1'b1);
        send_gate(16'sd3, 16'sd9, 16'sd0, 1'b1);
        send_gate(-16'sd32768, -16'sd32768, 16'sd0, 1'b1);
        program_setting(make_setting(MODE_MULT, -16'sd32768, Q_ONE, '0, Q_ONE, '0,
                                     Q_ONE, '0));
        send_gate(16'sd181, 16'sd181, 16'sd0, 1'b1);
        send_gate(16'sd32767, 16'sd32767, 16'sd0, 1'b1);
        send_gate(-16'sd200, 16'sd300, 16'sd0, 1'b1);
        send_gate(-16'sd32768, 16'sd1, 16'sd0, 1'b1);
        program_setting(make_setting(MODE_SUB, -16'sd32768, Q_ONE, '0, Q_ONE, '0,
                                     Q_ONE, '0));
        send_gate(-16'sd32767, 16'sd32767, 16'sd0, 1'b1);
        send_gate(16'sd5, -16'sd32768, 16'sd0, 1'b1);
        send_gate(16'sd0, -16'sd1, -16'sd32768, 1'b1);
        // unit gain product but opposite signs forces rescale
        program_setting(make_setting(MODE_ADD, -16'sd32768, Q_ONE, '0, Q_ONE, '0,
                                     -Q_ONE, '0));
        send_gate(16'sd10, 16'sd20, 16'sd0, 1'b1);
        send_gate(16'sd32767, -16'sd32768, 16'sd0, 1'b1);
        program_setting(make_setting(MODE_SUB, 16'sd32767, Q_MAX, Q_MIN, Q_MIN, Q_MAX,
                                     Q_MAX, Q_MIN));
        send_gate(16'sd32767, -16'sd32767, 16'sd0, 1'b1);
        send_gate(16'sd1, 16'sd2, 16'sd0, 1'b1);
        send_gate(-16'sd32768, 16'sd2, 16'sd0, 1'b1);

        for (int p = 0; p < 18; p++)
        begin
            if (p == 6)
                sender_idle_pct = 68;
            else if (p == 12)
                sender_idle_pct = 0;
            c = random_setting(p);
            program_setting(c);
            n = int'($urandom_range(50, 34));
            repeat (n)
                send_gate(pick_sample(c.bad), pick_sample(c.bad), 16'($urandom),
                          $urandom_range(99) < 85);
        end

        wait_idle();
        repeat (TAIL) @(posedge clk);
        fail_count += results_due.size();
        if (fail_count == 0)
            $display("[gate_field_combiner_top] OK");
        else
            $display("[gate_field_combiner_top] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/gfc_pkg.sv
sv/gfc_qmul.sv
sv/gate_field_combiner_top.sv
tb/testbench.sv
